### design/pdo_dm_pkg.sv
// shared types, codes and constants for the receive pdo demapper
`timescale 1ns / 1ps

package pdo_dm_pkg;

    localparam int SLOTS_DEF   = 4;
    localparam int ENTRIES_DEF = 8;

    // fixed by the widths of the transaction fields
    localparam int ACTION_W    = 2;
    localparam int SLOT_W      = 2;
    localparam int ENTRY_W     = 4;
    localparam int WORD_W      = 32;
    localparam int FID_W       = 11;
    localparam int PAYLOAD_W   = 64;
    localparam int INDEX_W     = 16;
    localparam int SUBINDEX_W  = 8;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int LEN_W       = 8;

    // holds any mapping count up to the largest entry count
    localparam int COUNT_W     = 7;
    // bit offset saturates at the payload width
    localparam int OFFSET_W    = 7;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [INDEX_W-1:0] DUMMY_LIMIT = 16'h1000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_COB = 2'd0,
        ACT_LOAD_MAP = 2'd1,
        ACT_FRAME    = 2'd2,
        ACT_NONE     = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_WRITE   = 2'd0,
        STAT_SKIP    = 2'd1,
        STAT_NOMATCH = 2'd2
    } status_t;

    // one frame resolved by the front, waiting for the back
    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic [COUNT_W-1:0]   count;
        logic [PAYLOAD_W-1:0] payload;
    } job_t;

    // state of the queue and back as seen by the front
    typedef struct packed {
        logic queue_full;
        logic queue_empty;
        logic back_idle;
    } drain_t;

endpackage

### design/pdo_dm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pdo_dm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                 aclk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/pdo_dm_front.sv
// front end: accepts transactions, keeps slot tables, matches frames
`timescale 1ns / 1ps

module pdo_dm_front #(
    parameter int SLOTS   = pdo_dm_pkg::SLOTS_DEF,
    parameter int ENTRIES = pdo_dm_pkg::ENTRIES_DEF,
    parameter int ADDR_W  = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [pdo_dm_pkg::ACTION_W-1:0] s_action,
    input  logic [pdo_dm_pkg::SLOT_W-1:0]   s_slot,
    input  logic [pdo_dm_pkg::ENTRY_W-1:0]  s_entry_number,
    input  logic [pdo_dm_pkg::WORD_W-1:0]   s_table_word,
    input  logic [pdo_dm_pkg::FID_W-1:0]    s_frame_id,
    input  logic [pdo_dm_pkg::PAYLOAD_W-1:0] s_frame_payload,
    input  pdo_dm_pkg::drain_t              drain,
    output logic                            job_push,
    output pdo_dm_pkg::job_t                job,
    output logic                            ram_we,
    output logic [ADDR_W-1:0]               ram_waddr,
    output logic [pdo_dm_pkg::WORD_W-1:0]   ram_wdata
);

    import pdo_dm_pkg::*;

    // the slot field reaches at most four slots
    localparam int LIVE_SLOTS = (SLOTS < (1 << SLOT_W)) ? SLOTS : (1 << SLOT_W);

    logic [WORD_W-1:0]  cob_reg    [LIVE_SLOTS];
    logic [WORD_W-1:0]  cob_next   [LIVE_SLOTS];
    logic [LIVE_SLOTS-1:0] loaded_reg, loaded_next;
    logic [COUNT_W-1:0] count_reg  [LIVE_SLOTS];
    logic [COUNT_W-1:0] count_next [LIVE_SLOTS];

    action_t            action;
    logic               slot_ok;
    logic               entry_ok;
    logic               is_map_word;
    logic               accept;
    logic               hit;
    logic [SLOT_W-1:0]  hit_slot;
    logic [COUNT_W-1:0] hit_count;
    logic [COUNT_W-1:0] sat_count;

    assign action      = action_t'(s_action);
    assign slot_ok     = 32'(s_slot) < SLOTS;
    assign entry_ok    = (s_entry_number != '0) && (32'(s_entry_number) <= ENTRIES);
    assign is_map_word = (action == ACT_LOAD_MAP) && (s_entry_number != '0);

    // mapping words are read by the back, so they change only once it has drained
    always_comb begin
        s_ready = 1'b1;
        if (is_map_word) begin
            s_ready = drain.back_idle && drain.queue_empty;
        end else if (action == ACT_FRAME) begin
            s_ready = !drain.queue_full;
        end
    end

    assign accept = s_valid && s_ready;

    assign sat_count = (s_table_word > WORD_W'(ENTRIES)) ? COUNT_W'(ENTRIES)
                                                         : s_table_word[COUNT_W-1:0];

    // lowest loaded slot wins
    always_comb begin
        hit       = 1'b0;
        hit_slot  = '0;
        hit_count = '0;
        for (int s = LIVE_SLOTS - 1; s >= 0; s--) begin
            if (loaded_reg[s] && (cob_reg[s] == WORD_W'(s_frame_id))) begin
                hit       = 1'b1;
                hit_slot  = SLOT_W'(s);
                hit_count = count_reg[s];
            end
        end
    end

    always_comb begin
        job.slot    = hit_slot;
        job.count   = hit ? hit_count : '0;
        job.payload = s_frame_payload;
        job_push    = accept && (action == ACT_FRAME);
    end

    assign ram_we    = accept && is_map_word && slot_ok && entry_ok;
    assign ram_waddr = ADDR_W'(32'(s_slot) * ENTRIES + 32'(s_entry_number) - 1);
    assign ram_wdata = s_table_word;

    always_comb begin
        loaded_next = loaded_reg;
        for (int s = 0; s < LIVE_SLOTS; s++) begin
            cob_next[s]   = cob_reg[s];
            count_next[s] = count_reg[s];
        end
        if (accept && slot_ok) begin
            case (action)
                ACT_LOAD_COB: begin
                    cob_next[s_slot]    = s_table_word;
                    loaded_next[s_slot] = 1'b1;
                end
                ACT_LOAD_MAP: begin
                    if (s_entry_number == '0) begin
                        count_next[s_slot] = sat_count;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loaded_reg <= '0;
            for (int s = 0; s < LIVE_SLOTS; s++) begin
                cob_reg[s]   <= '0;
                count_reg[s] <= '0;
            end
        end else begin
            loaded_reg <= loaded_next;
            for (int s = 0; s < LIVE_SLOTS; s++) begin
                cob_reg[s]   <= cob_next[s];
                count_reg[s] <= count_next[s];
            end
        end
    end

endmodule

### design/pdo_dm_fifo.sv
// short job queue between front and back
`timescale 1ns / 1ps

module pdo_dm_fifo (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pdo_dm_pkg::job_t push_data,
    input  logic             pop,
    output pdo_dm_pkg::job_t pop_data,
    output logic             full,
    output logic             empty
);

    import pdo_dm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic             do_push;
    logic             do_pop;

    assign full     = fill_reg == CNT_W'(QUEUE_DEPTH);
    assign empty    = fill_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        fill_next = fill_reg;
        if (do_push) begin
            wptr_next = (wptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rptr_next = (rptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

### design/pdo_dm_back.sv
// back end: walks mapping entries, cuts fields, drives the result register
`timescale 1ns / 1ps

module pdo_dm_back #(
    parameter int ENTRIES = pdo_dm_pkg::ENTRIES_DEF,
    parameter int ADDR_W  = 5
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    input  pdo_dm_pkg::job_t                  job,
    output logic                              job_pop,
    output logic                              back_idle,
    output logic [ADDR_W-1:0]                 ram_raddr,
    input  logic [pdo_dm_pkg::WORD_W-1:0]     ram_rdata,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pdo_dm_pkg::INDEX_W-1:0]    m_obj_index,
    output logic [pdo_dm_pkg::SUBINDEX_W-1:0] m_dest_subindex,
    output logic [pdo_dm_pkg::VALUE_W-1:0]    m_field_value,
    output logic [pdo_dm_pkg::STATUS_W-1:0]   m_status,
    output logic                              m_last
);

    import pdo_dm_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SUM_W = OFFSET_W + 2;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [OFFSET_W-1:0]  offset_reg, offset_next;

    logic                  m_valid_reg, m_valid_next;
    logic [INDEX_W-1:0]    index_reg, index_next;
    logic [SUBINDEX_W-1:0] sub_reg, sub_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    status_t               status_reg, status_next;
    logic                  last_reg, last_next;

    logic                  out_free;
    logic [INDEX_W-1:0]    w_index;
    logic [SUBINDEX_W-1:0] w_sub;
    logic [LEN_W-1:0]      w_len;
    logic [PAYLOAD_W-1:0]  shifted;
    logic [VALUE_W-1:0]    mask;
    logic [VALUE_W-1:0]    field;
    logic [SUM_W-1:0]      offset_sum;
    logic                  is_last;

    assign out_free = !m_valid_reg || m_ready;

    assign w_index = ram_rdata[31:16];
    assign w_sub   = ram_rdata[15:8];
    assign w_len   = ram_rdata[LEN_W-1:0];

    // true field extraction, bits past the payload read as zero
    assign shifted = payload_reg >> offset_reg[5:0];
    assign mask    = (w_len >= LEN_W'(VALUE_W)) ? '1
                   : ((VALUE_W'(1) << w_len[4:0]) - VALUE_W'(1));
    assign field   = offset_reg[OFFSET_W-1] ? '0 : (shifted[VALUE_W-1:0] & mask);

    assign offset_sum = SUM_W'(offset_reg) + SUM_W'(w_len);
    assign is_last    = (COUNT_W'(idx_reg) + COUNT_W'(1)) == count_reg;

    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        count_next   = count_reg;
        payload_next = payload_reg;
        idx_next     = idx_reg;
        offset_next  = offset_reg;
        m_valid_next = m_valid_reg && !m_ready;
        index_next   = index_reg;
        sub_next     = sub_reg;
        value_next   = value_reg;
        status_next  = status_reg;
        last_next    = last_reg;
        job_pop      = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (job_valid && out_free) begin
                    job_pop = 1'b1;
                    if (job.count == '0) begin
                        m_valid_next = 1'b1;
                        index_next   = '0;
                        sub_next     = '0;
                        value_next   = '0;
                        status_next  = STAT_NOMATCH;
                        last_next    = 1'b1;
                    end else begin
                        state_next   = S_RUN;
                        slot_next    = job.slot;
                        count_next   = job.count;
                        payload_next = job.payload;
                        idx_next     = '0;
                        offset_next  = '0;
                    end
                end
            end
            S_RUN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    index_next   = w_index;
                    sub_next     = w_sub;
                    last_next    = is_last;
                    if (w_index >= DUMMY_LIMIT) begin
                        value_next  = field;
                        status_next = STAT_WRITE;
                    end else begin
                        value_next  = '0;
                        status_next = STAT_SKIP;
                    end
                    offset_next = (offset_sum >= SUM_W'(PAYLOAD_W)) ? OFFSET_W'(PAYLOAD_W)
                                                                    : offset_sum[OFFSET_W-1:0];
                    idx_next    = idx_reg + IDX_W'(1);
                    if (is_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // read address follows the next entry so the data lines up with idx_reg
    assign ram_raddr = ADDR_W'(32'(slot_next) * ENTRIES + 32'(idx_next));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            slot_reg    <= slot_next;
            count_reg   <= count_next;
            payload_reg <= payload_next;
            idx_reg     <= idx_next;
            offset_reg  <= offset_next;
            index_reg   <= index_next;
            sub_reg     <= sub_next;
            value_reg   <= value_next;
            status_reg  <= status_next;
            last_reg    <= last_next;
        end
    end

    assign back_idle       = state_reg == S_IDLE;
    assign m_valid         = m_valid_reg;
    assign m_obj_index     = index_reg;
    assign m_dest_subindex = sub_reg;
    assign m_field_value   = value_reg;
    assign m_status        = status_reg;
    assign m_last          = last_reg;

endmodule

### design/pdo_receive_demapper.sv
// top level of the receive pdo demapper
//
//  channel  direction  transaction
//  s_       in         load cob word, load mapping count or word, or process frame
//  m_       out        one write request, skip or no-match status per result
//
//  a mapping word load waits until the back end has drained
//  a frame is matched in the cycle it is accepted and queued
//  the back end pops a frame while idle, then gives one result per mapping entry,
//  reading the entries in order through the single read port of the mapping ram;
//  a frame with no match gives a single no-match result
//  the job queue holds two frames; m_ready low stalls the back end, then the full
//  queue holds off frames and mapping word loads at s_ready
//  reset is synchronous and clears the slot tables; mapping words need no clearing
`timescale 1ns / 1ps

module pdo_receive_demapper #(
    parameter int SLOTS   = pdo_dm_pkg::SLOTS_DEF,
    parameter int ENTRIES = pdo_dm_pkg::ENTRIES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pdo_dm_pkg::ACTION_W-1:0]   s_action,
    input  logic [pdo_dm_pkg::SLOT_W-1:0]     s_slot,
    input  logic [pdo_dm_pkg::ENTRY_W-1:0]    s_entry_number,
    input  logic [pdo_dm_pkg::WORD_W-1:0]     s_table_word,
    input  logic [pdo_dm_pkg::FID_W-1:0]      s_frame_id,
    input  logic [pdo_dm_pkg::PAYLOAD_W-1:0]  s_frame_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pdo_dm_pkg::INDEX_W-1:0]    m_obj_index,
    output logic [pdo_dm_pkg::SUBINDEX_W-1:0] m_dest_subindex,
    output logic [pdo_dm_pkg::VALUE_W-1:0]    m_field_value,
    output logic [pdo_dm_pkg::STATUS_W-1:0]   m_status,
    output logic                              m_last
);

    import pdo_dm_pkg::*;

    localparam int LIVE_SLOTS = (SLOTS < (1 << SLOT_W)) ? SLOTS : (1 << SLOT_W);
    localparam int RAM_DEPTH  = LIVE_SLOTS * ENTRIES;
    localparam int ADDR_W     = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;

    drain_t              drain;
    logic                job_push;
    job_t                push_job;
    logic                job_pop;
    job_t                pop_job;
    logic                queue_full;
    logic                queue_empty;
    logic                back_idle;
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    assign drain.queue_full  = queue_full;
    assign drain.queue_empty = queue_empty;
    assign drain.back_idle   = back_idle;

    pdo_dm_front #(
        .SLOTS   (SLOTS),
        .ENTRIES (ENTRIES),
        .ADDR_W  (ADDR_W)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_slot          (s_slot),
        .s_entry_number  (s_entry_number),
        .s_table_word    (s_table_word),
        .s_frame_id      (s_frame_id),
        .s_frame_payload (s_frame_payload),
        .drain           (drain),
        .job_push        (job_push),
        .job             (push_job),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata)
    );

    pdo_dm_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_push),
        .push_data (push_job),
        .pop       (job_pop),
        .pop_data  (pop_job),
        .full      (queue_full),
        .empty     (queue_empty)
    );

    pdo_dm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_map_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pdo_dm_back #(
        .ENTRIES (ENTRIES),
        .ADDR_W  (ADDR_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .job_valid       (!queue_empty),
        .job             (pop_job),
        .job_pop         (job_pop),
        .back_idle       (back_idle),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_obj_index     (m_obj_index),
        .m_dest_subindex (m_dest_subindex),
        .m_field_value   (m_field_value),
        .m_status        (m_status),
        .m_last          (m_last)
    );

endmodule

### design/pdo_dm_checker.sv
// port-level checks for the receive pdo demapper, bound to the top level
`timescale 1ns / 1ps

module pdo_dm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [pdo_dm_pkg::INDEX_W-1:0]    m_obj_index,
    input logic [pdo_dm_pkg::SUBINDEX_W-1:0] m_dest_subindex,
    input logic [pdo_dm_pkg::VALUE_W-1:0]    m_field_value,
    input logic [pdo_dm_pkg::STATUS_W-1:0]   m_status,
    input logic                              m_last
);

    import pdo_dm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_obj_index)
            && $stable(m_dest_subindex) && $stable(m_field_value)
            && $stable(m_status) && $stable(m_last))
        else $error("result changed while stalled");

    // no-match result is a lone, empty transaction
    a_nomatch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_NOMATCH) |-> m_last && (m_obj_index == '0)
            && (m_dest_subindex == '0) && (m_field_value == '0))
        else $error("no-match result malformed");

    // skips carry a dummy index and no data
    a_skip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_SKIP) |-> (m_obj_index < DUMMY_LIMIT)
            && (m_field_value == '0))
        else $error("skip result malformed");

    // write requests never target the dummy range
    a_write: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_WRITE) |-> m_obj_index >= DUMMY_LIMIT)
        else $error("write request to dummy index");

endmodule

bind pdo_receive_demapper pdo_dm_checker u_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_obj_index     (m_obj_index),
    .m_dest_subindex (m_dest_subindex),
    .m_field_value   (m_field_value),
    .m_status        (m_status),
    .m_last          (m_last)
);
